// File: src/tlv_pkg.sv
// Shared types and constants for the record payload validator.
package tlv_pkg;

  // Field widths.
  localparam int unsigned KeyLenW    = 8;
  localparam int unsigned TypeW      = 8;
  localparam int unsigned ValLenW    = 16;
  localparam int unsigned BodyLeftW  = 17;
  localparam int unsigned RecCountW  = 11;
  localparam int unsigned EntryW     = 10;
  localparam int unsigned ByteCountW = 17;
  localparam int unsigned ExpectedW  = 16;
  localparam int unsigned CfgDataW   = 17;
  localparam int unsigned CfgIdxW    = 2;

  // The effective quota never goes above this.
  localparam logic [ByteCountW-1:0] QuotaCeiling = 17'h10000;

  // Register reset values.
  localparam logic [7:0]  RstMaxKeyLen = 8'd64;
  localparam logic [15:0] RstMaxStrLen = 16'd4096;
  localparam logic [9:0]  RstMaxEntries = 10'd128;
  localparam logic [16:0] RstQuota      = 17'd16384;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMaxKeyLen  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxStrLen  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxEntries = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgQuota      = 2'd3;

  // Record value types.
  localparam logic [TypeW-1:0] TypeBool   = 8'd1;
  localparam logic [TypeW-1:0] TypeInt    = 8'd2;
  localparam logic [TypeW-1:0] TypeNumber = 8'd3;
  localparam logic [TypeW-1:0] TypeString = 8'd4;

  // Fixed value lengths for the scalar types.
  localparam logic [ValLenW-1:0] LenBool   = 16'd1;
  localparam logic [ValLenW-1:0] LenInt    = 16'd4;
  localparam logic [ValLenW-1:0] LenNumber = 16'd8;

  // Result status codes; the sticky error uses the same codes.
  typedef enum logic [2:0] {
    ST_VALID      = 3'd0,
    ST_MALFORMED  = 3'd1,
    ST_TOO_MANY   = 3'd2,
    ST_MISMATCH   = 3'd3,
    ST_OVER_QUOTA = 3'd4
  } status_t;

  // Where the parser stands within a record.
  typedef enum logic [2:0] {
    HP_KEY_LEN = 3'd0,
    HP_TYPE    = 3'd1,
    HP_VLEN_LO = 3'd2,
    HP_VLEN_HI = 3'd3,
    HP_BODY    = 3'd4
  } hdr_pos_t;

  // One input item.
  typedef struct packed {
    logic [7:0]           byte_value;
    logic                 byte_present;
    logic                 last;
    logic [ExpectedW-1:0] expected_entries;
  } item_t;

  // Configuration registers as seen by the parser.
  typedef struct packed {
    logic [7:0]  max_key_length;
    logic [15:0] max_string_length;
    logic [9:0]  max_entries;
    logic [16:0] quota_bytes;
  } cfg_t;

  // One result item.
  typedef struct packed {
    status_t               status;
    logic [EntryW-1:0]     record_total;
    logic [ByteCountW-1:0] payload_length;
  } result_t;

endpackage

// File: src/tlv_core.sv
// Stream state and per-byte record checks of the payload validator.
module tlv_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  tlv_pkg::item_t   item,
  input  tlv_pkg::cfg_t    cfg,
  output tlv_pkg::result_t res
);
  import tlv_pkg::*;

  hdr_pos_t               hdr_pos_r, hdr_pos_nxt, hdr_pos_upd;
  logic [KeyLenW-1:0]     key_len_r, key_len_nxt, key_len_upd;
  logic [TypeW-1:0]       type_r, type_nxt, type_upd;
  logic [ValLenW-1:0]     val_len_r, val_len_nxt, val_len_upd;
  logic [BodyLeftW-1:0]   body_left_r, body_left_nxt, body_left_upd;
  logic [RecCountW-1:0]   rec_count_r, rec_count_nxt, rec_count_upd;
  logic [ByteCountW-1:0]  byte_count_r, byte_count_nxt, byte_count_upd;
  status_t                err_r, err_nxt, err_upd;

  logic [ByteCountW-1:0]  quota_eff;
  logic [ValLenW-1:0]     val_len_full;
  logic                   hdr_ok;
  logic [BodyLeftW-1:0]   body_left_dec;
  logic [RecCountW-1:0]   rec_count_inc;
  status_t                status;

  // Quota values above the ceiling act as the ceiling.
  assign quota_eff = (cfg.quota_bytes > QuotaCeiling) ? QuotaCeiling : cfg.quota_bytes;

  // Header check, evaluated as the high value-length byte arrives.
  assign val_len_full = {item.byte_value, val_len_r[7:0]};

  always_comb begin
    hdr_ok = (key_len_r != '0) && (key_len_r <= cfg.max_key_length);
    unique case (type_r)
      TypeBool:   hdr_ok = hdr_ok && (val_len_full == LenBool);
      TypeInt:    hdr_ok = hdr_ok && (val_len_full == LenInt);
      TypeNumber: hdr_ok = hdr_ok && (val_len_full == LenNumber);
      TypeString: hdr_ok = hdr_ok && (val_len_full <= cfg.max_string_length);
      default:    hdr_ok = 1'b0;
    endcase
  end

  assign body_left_dec = (body_left_r != '0) ? body_left_r - 1'b1 : body_left_r;
  assign rec_count_inc = rec_count_r + 1'b1;

  // Quota count and record parsing for one byte.
  always_comb begin
    hdr_pos_upd    = hdr_pos_r;
    key_len_upd    = key_len_r;
    type_upd       = type_r;
    val_len_upd    = val_len_r;
    body_left_upd  = body_left_r;
    rec_count_upd  = rec_count_r;
    byte_count_upd = byte_count_r;
    err_upd        = err_r;
    if (item.byte_present) begin
      // The byte count stops once it has passed the quota.
      if (byte_count_r <= quota_eff) begin
        byte_count_upd = byte_count_r + 1'b1;
        if (byte_count_r == quota_eff) begin
          err_upd = ST_OVER_QUOTA;
        end
      end
      // Parsing stops after the first error.
      if (err_upd == ST_VALID) begin
        unique case (hdr_pos_r)
          HP_KEY_LEN: begin
            key_len_upd = item.byte_value;
            hdr_pos_upd = HP_TYPE;
          end
          HP_TYPE: begin
            type_upd    = item.byte_value;
            hdr_pos_upd = HP_VLEN_LO;
          end
          HP_VLEN_LO: begin
            val_len_upd = {8'h00, item.byte_value};
            hdr_pos_upd = HP_VLEN_HI;
          end
          HP_VLEN_HI: begin
            val_len_upd = val_len_full;
            if (!hdr_ok) begin
              err_upd = ST_MALFORMED;
            end else begin
              body_left_upd = {9'd0, key_len_r} + {1'b0, val_len_full};
              hdr_pos_upd   = HP_BODY;
            end
          end
          HP_BODY: begin
            body_left_upd = body_left_dec;
            if (body_left_dec == '0) begin
              hdr_pos_upd   = HP_KEY_LEN;
              rec_count_upd = rec_count_inc;
              if (rec_count_inc > {1'b0, cfg.max_entries}) begin
                err_upd = ST_TOO_MANY;
              end
            end
          end
          default: hdr_pos_upd = hdr_pos_r;
        endcase
      end
    end
  end

  // Final status, then the stream state returns to reset after the last item.
  always_comb begin
    priority if (err_upd != ST_VALID) begin
      status = err_upd;
    end else if (hdr_pos_upd != HP_KEY_LEN) begin
      status = ST_MALFORMED;
    end else if ({5'd0, rec_count_upd} != item.expected_entries) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_VALID;
    end

    res.status         = status;
    res.record_total   = (status == ST_VALID) ? rec_count_upd[EntryW-1:0] : '0;
    res.payload_length = (status == ST_VALID) ? byte_count_upd : '0;

    hdr_pos_nxt    = hdr_pos_r;
    key_len_nxt    = key_len_r;
    type_nxt       = type_r;
    val_len_nxt    = val_len_r;
    body_left_nxt  = body_left_r;
    rec_count_nxt  = rec_count_r;
    byte_count_nxt = byte_count_r;
    err_nxt        = err_r;
    if (step) begin
      if (item.last) begin
        hdr_pos_nxt    = HP_KEY_LEN;
        key_len_nxt    = '0;
        type_nxt       = '0;
        val_len_nxt    = '0;
        body_left_nxt  = '0;
        rec_count_nxt  = '0;
        byte_count_nxt = '0;
        err_nxt        = ST_VALID;
      end else begin
        hdr_pos_nxt    = hdr_pos_upd;
        key_len_nxt    = key_len_upd;
        type_nxt       = type_upd;
        val_len_nxt    = val_len_upd;
        body_left_nxt  = body_left_upd;
        rec_count_nxt  = rec_count_upd;
        byte_count_nxt = byte_count_upd;
        err_nxt        = err_upd;
      end
    end
  end

  // Stream state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r    <= HP_KEY_LEN;
      key_len_r    <= '0;
      type_r       <= '0;
      val_len_r    <= '0;
      body_left_r  <= '0;
      rec_count_r  <= '0;
      byte_count_r <= '0;
      err_r        <= ST_VALID;
    end else begin
      hdr_pos_r    <= hdr_pos_nxt;
      key_len_r    <= key_len_nxt;
      type_r       <= type_nxt;
      val_len_r    <= val_len_nxt;
      body_left_r  <= body_left_nxt;
      rec_count_r  <= rec_count_nxt;
      byte_count_r <= byte_count_nxt;
      err_r        <= err_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A record body in progress always has bytes still due.
  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_pos_r == HP_BODY) |-> (body_left_r != '0))
    else $error("body state with no bytes left");

  // The sticky error never holds the count mismatch code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ST_MISMATCH)
    else $error("sticky error holds mismatch code");

  // The byte count never runs more than one past the quota ceiling.
  a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= QuotaCeiling + 1'b1)
    else $error("byte count beyond quota ceiling");

  // The last item leaves the stream state cleared.
  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last) |=> (byte_count_r == '0 && rec_count_r == '0 &&
                             hdr_pos_r == HP_KEY_LEN && err_r == ST_VALID))
    else $error("stream state not cleared after last item");
`endif

endmodule

// File: src/tlv_record_payload_validator_top.sv
// Top level of the record payload validator: registers, item and result stages.
// A result is registered onto out_valid when its last item leaves the item stage.
// Throughput: one item per cycle; the input stalls only while a last item waits
// behind a result that has not been taken.
// Reset (synchronous, rst_n low): configuration returns to its defaults, stream
// state clears, and both stages empty.
module tlv_record_payload_validator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte_value,
  input  logic                                in_byte_present,
  input  logic                                in_last,
  input  logic [tlv_pkg::ExpectedW-1:0]       in_expected_entries,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic [tlv_pkg::EntryW-1:0]          out_record_total,
  output logic [tlv_pkg::ByteCountW-1:0]      out_payload_length,
  input  logic                                cfg_we,
  input  logic [tlv_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [tlv_pkg::CfgDataW-1:0]        cfg_wdata
);
  import tlv_pkg::*;

  cfg_t    cfg_r;
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t core_res;
  logic    in_accept;
  logic    out_free;
  logic    s1_go;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_key_length    <= RstMaxKeyLen;
      cfg_r.max_string_length <= RstMaxStrLen;
      cfg_r.max_entries       <= RstMaxEntries;
      cfg_r.quota_bytes       <= RstQuota;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMaxKeyLen:  cfg_r.max_key_length    <= cfg_wdata[7:0];
        CfgMaxStrLen:  cfg_r.max_string_length <= cfg_wdata[15:0];
        CfgMaxEntries: cfg_r.max_entries       <= cfg_wdata[9:0];
        CfgQuota:      cfg_r.quota_bytes       <= cfg_wdata[16:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  // Handshake: the item stage moves on unless it holds a last item with nowhere to go.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!s1_item_r.last || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_go && s1_item_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.byte_value       <= in_byte_value;
      s1_item_r.byte_present     <= in_byte_present;
      s1_item_r.last             <= in_last;
      s1_item_r.expected_entries <= in_expected_entries;
    end
    if (s1_go && s1_item_r.last) begin
      out_res_r <= core_res;
    end
  end

  tlv_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_record_total   = out_res_r.record_total;
  assign out_payload_length = out_res_r.payload_length;

endmodule

// File: verif/tlv_record_payload_validator_top_tb.sv
// Self-checking testbench for the record payload validator: table-driven and random payloads.
module tlv_record_payload_validator_top_tb;
  import tlv_pkg::*;

  localparam int PhaseCount    = 10;
  localparam int PhaseItems    = 100;
  localparam int SinkHoldCycles = 300;
  localparam int SettleCycles  = 4;
  localparam int DrainCycles   = 8;
  localparam int CycleLimit    = 400000;

  // One row of the directed table: a stimulus item and, where it is obvious,
  // the report that it must produce.
  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte_value = '0;
  logic                  in_byte_present = 1'b0;
  logic                  in_last = 1'b0;
  logic [ExpectedW-1:0]  in_expected_entries = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_status;
  logic [EntryW-1:0]     out_record_total;
  logic [ByteCountW-1:0] out_payload_length;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_wdata = '0;

  // Limits as currently programmed into the block.
  logic [7:0]  lim_key     = RstMaxKeyLen;
  logic [15:0] lim_str     = RstMaxStrLen;
  logic [9:0]  lim_entries = RstMaxEntries;
  logic [16:0] lim_quota   = RstQuota;

  // Parser state of the payload being checked.
  hdr_pos_t              hdr_pos    = HP_KEY_LEN;
  logic [KeyLenW-1:0]    key_len    = '0;
  logic [TypeW-1:0]      val_type   = '0;
  logic [ValLenW-1:0]    val_len    = '0;
  logic [BodyLeftW-1:0]  body_left  = '0;
  logic [RecCountW-1:0]  rec_count  = '0;
  logic [ByteCountW-1:0] byte_count = '0;
  status_t               sticky     = ST_VALID;

  result_t  pending_reports[$];
  item_t    payload_q[$];
  dir_row_t dir_table[$];
  int       fault_count = 0;
  int       cycle_count = 0;
  bit       sink_hold_req = 1'b0;
  bit       quiet = 1'b0;

  tlv_record_payload_validator_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_byte_present     (in_byte_present),
    .in_last             (in_last),
    .in_expected_entries (in_expected_entries),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_record_total    (out_record_total),
    .out_payload_length  (out_payload_length),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Runs one accepted item through the validator's rules and returns 1 with
  // the report when the item closes a payload.
  function automatic bit validate_payload_item(input item_t it, output result_t rep);
    logic [ByteCountW-1:0] quota_now;
    bit                    hdr_good;
    status_t               verdict;
    quota_now = (lim_quota > QuotaCeiling) ? QuotaCeiling : lim_quota;
    rep = '0;
    if (it.byte_present) begin
      // Bytes count toward the quota even after an error, until it is passed.
      if (byte_count <= quota_now) begin
        byte_count = byte_count + 1'b1;
        if (byte_count > quota_now) sticky = ST_OVER_QUOTA;
      end
      if (sticky == ST_VALID) begin
        if (hdr_pos != HP_BODY) begin
          case (hdr_pos)
            HP_KEY_LEN: key_len = it.byte_value;
            HP_TYPE:    val_type = it.byte_value;
            HP_VLEN_LO: val_len = {8'h00, it.byte_value};
            default:    val_len[15:8] = it.byte_value;
          endcase
          if (hdr_pos != HP_VLEN_HI) begin
            hdr_pos = hdr_pos_t'(hdr_pos + 3'd1);
          end else begin
            // The header is complete: check it against the limits.
            hdr_good = (key_len != 0) && (key_len <= lim_key);
            case (val_type)
              TypeBool:   hdr_good = hdr_good && (val_len == LenBool);
              TypeInt:    hdr_good = hdr_good && (val_len == LenInt);
              TypeNumber: hdr_good = hdr_good && (val_len == LenNumber);
              TypeString: hdr_good = hdr_good && (val_len <= lim_str);
              default:    hdr_good = 1'b0;
            endcase
            if (!hdr_good) begin
              sticky = ST_MALFORMED;
            end else begin
              body_left = BodyLeftW'(key_len) + BodyLeftW'(val_len);
              hdr_pos = HP_BODY;
            end
          end
        end else begin
          // Body byte; the record counts once its last byte is in.
          if (body_left != 0) body_left = body_left - 1'b1;
          if (body_left == 0) begin
            hdr_pos = HP_KEY_LEN;
            rec_count = rec_count + 1'b1;
            if (rec_count > lim_entries) sticky = ST_TOO_MANY;
          end
        end
      end
    end
    if (!it.last) return 1'b0;
    // End of payload: form the report and start over.
    verdict = sticky;
    if (verdict == ST_VALID && hdr_pos != HP_KEY_LEN) verdict = ST_MALFORMED;
    if (verdict == ST_VALID && rec_count != it.expected_entries) verdict = ST_MISMATCH;
    rep.status = verdict;
    if (verdict == ST_VALID) begin
      rep.record_total = rec_count[EntryW-1:0];
      rep.payload_length = byte_count;
    end
    hdr_pos = HP_KEY_LEN;
    key_len = '0;
    val_type = '0;
    val_len = '0;
    body_left = '0;
    rec_count = '0;
    byte_count = '0;
    sticky = ST_VALID;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic present, input logic fin,
                                  input logic [15:0] announced, input bit typed = 1'b0,
                                  input status_t st = ST_VALID, input int cnt = 0,
                                  input int len = 0);
    dir_row_t row;
    row.stim.byte_value = b;
    row.stim.byte_present = present;
    row.stim.last = fin;
    row.stim.expected_entries = announced;
    row.typed = typed;
    row.want.status = st;
    row.want.record_total = EntryW'(cnt);
    row.want.payload_length = ByteCountW'(len);
    dir_table.push_back(row);
  endfunction

  function automatic item_t payload_byte(input logic [7:0] b);
    item_t it;
    it.byte_value = b;
    it.byte_present = 1'b1;
    it.last = 1'b0;
    it.expected_entries = ExpectedW'($urandom);
    return it;
  endfunction

  // Offers one item, waits until it is taken, records the expected report and
  // then sometimes idles for a burst.
  task automatic offer_item(input item_t it, input bit typed, input result_t want);
    result_t rep;
    in_valid <= 1'b1;
    in_byte_value <= it.byte_value;
    in_byte_present <= it.byte_present;
    in_last <= it.last;
    in_expected_entries <= it.expected_entries;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (validate_payload_item(it, rep)) pending_reports.push_back(typed ? want : rep);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Programs all four limits once the block has gone idle.
  task automatic program_limits(input logic [7:0] k, input logic [15:0] s,
                                input logic [9:0] e, input logic [16:0] q);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgMaxKeyLen;
    cfg_wdata <= CfgDataW'(k);
    @(posedge clk);
    cfg_index <= CfgMaxStrLen;
    cfg_wdata <= CfgDataW'(s);
    @(posedge clk);
    cfg_index <= CfgMaxEntries;
    cfg_wdata <= CfgDataW'(e);
    @(posedge clk);
    cfg_index <= CfgQuota;
    cfg_wdata <= CfgDataW'(q);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_key = k;
    lim_str = s;
    lim_entries = e;
    lim_quota = q;
  endtask

  // Appends one record; a broken one carries a bad header, or a fully random one.
  task automatic push_record(input bit broken);
    logic [7:0]  klen;
    logic [7:0]  vtype;
    logic [15:0] vlen;
    int          klim;
    int          slim;
    int          n;
    vtype = 8'($urandom_range(1, 4));
    klim = (lim_key == 0) ? 1 : ((lim_key < 6) ? int'(lim_key) : 6);
    klen = 8'($urandom_range(1, klim));
    if (lim_key != 0 && $urandom_range(0, 39) == 0) klen = lim_key;
    case (vtype)
      TypeBool:   vlen = LenBool;
      TypeInt:    vlen = LenInt;
      TypeNumber: vlen = LenNumber;
      default: begin
        slim = (lim_str < 8) ? int'(lim_str) : 8;
        vlen = 16'($urandom_range(0, slim));
      end
    endcase
    if (broken) begin
      case ($urandom_range(0, 4))
        0: klen = 8'h00;
        1: klen = (lim_key == 8'hFF) ? 8'h00 : lim_key + 8'd1;
        2: vtype = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(5, 255));
        3: begin
          if (vtype != TypeString) vlen = vlen + 16'($urandom_range(1, 65535));
          else if (lim_str != 16'hFFFF) vlen = lim_str + 16'd1;
          else vtype = 8'h00;
        end
        default: begin
          klen = 8'($urandom);
          vtype = 8'($urandom);
          vlen = 16'($urandom);
        end
      endcase
    end
    payload_q.push_back(payload_byte(klen));
    payload_q.push_back(payload_byte(vtype));
    payload_q.push_back(payload_byte(vlen[7:0]));
    payload_q.push_back(payload_byte(vlen[15:8]));
    n = broken ? $urandom_range(0, 3) : int'(klen) + int'(vlen);
    repeat (n) payload_q.push_back(payload_byte(8'($urandom)));
  endtask

  // Builds one payload: mostly well-formed records with random content, the
  // rest broken headers, truncated records, noise and empty payloads.
  task automatic build_payload();
    int    kind;
    int    recs;
    int    broken_at;
    int    cut;
    int    k;
    item_t it;
    logic [15:0] announced;
    payload_q.delete();
    kind = $urandom_range(0, 9);
    recs = $urandom_range(0, 4);
    if (kind <= 7) begin
      if (kind == 6) recs = recs + 1;
      broken_at = (kind == 6) ? $urandom_range(0, recs - 1) : -1;
      for (k = 0; k < recs; k++) push_record(k == broken_at);
      if (kind == 7 && payload_q.size() > 1) begin
        cut = $urandom_range(1, payload_q.size() - 1);
        while (payload_q.size() > cut) void'(payload_q.pop_back());
      end
    end else if (kind == 8) begin
      recs = 0;
      repeat ($urandom_range(1, 20)) payload_q.push_back(payload_byte(8'($urandom)));
    end else begin
      recs = 0;
    end
    case ($urandom_range(0, 7))
      0:       announced = 16'($urandom);
      1:       announced = 16'(recs + 1);
      default: announced = 16'(recs);
    endcase
    // Close on the final byte, or with a bare end marker.
    if (payload_q.size() > 0 && $urandom_range(0, 3) != 0) begin
      it = payload_q.pop_back();
    end else begin
      it = payload_byte(8'($urandom));
      it.byte_present = 1'b0;
    end
    it.last = 1'b1;
    it.expected_entries = announced;
    payload_q.push_back(it);
    // A bare item somewhere before the end must change nothing.
    if ($urandom_range(0, 4) == 0) begin
      it = payload_byte(8'($urandom));
      it.byte_present = 1'b0;
      payload_q.insert($urandom_range(0, payload_q.size() - 1), it);
    end
  endtask

  // Result side: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        out_stall <= 1'b1;
        repeat (SinkHoldCycles) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Compare each report taken from the block with the oldest expectation.
  always @(posedge clk) begin : check_reports
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got status %0d count %0d length %0d",
                 $time, out_status, out_record_total, out_payload_length);
        fault_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          fault_count++;
        end
        if (out_record_total !== want.record_total) begin
          $display("%0t: record_total expected %0d, got %0d",
                   $time, want.record_total, out_record_total);
          fault_count++;
        end
        if (out_payload_length !== want.payload_length) begin
          $display("%0t: payload_length expected %0d, got %0d",
                   $time, want.payload_length, out_payload_length);
          fault_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tlv_record_payload_validator_top_tb: FAIL");
    $finish;
  end

  // Stimulus: reset, the directed table, then random payloads over several limit settings.
  initial begin
    int      phase;
    int      sent;
    result_t no_report;
    no_report = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bare item, then empty payloads with the count matching and not.
    add_row(8'hFF, 1'b0, 1'b0, 16'hFFFF);
    add_row(8'h00, 1'b0, 1'b1, 16'h0000, 1'b1, ST_VALID, 0, 0);
    add_row(8'h5A, 1'b0, 1'b1, 16'hFFFF, 1'b1, ST_MISMATCH, 0, 0);
    // String record with an empty value.
    add_row(8'h01, 1'b1, 1'b0, 16'hFFFF);
    add_row(TypeString, 1'b1, 1'b0, 16'h0000);
    add_row(8'h00, 1'b1, 1'b0, 16'h0000);
    add_row(8'h00, 1'b1, 1'b0, 16'h0000);
    add_row(8'hFF, 1'b1, 1'b1, 16'h0001, 1'b1, ST_VALID, 1, 5);
    // Bool record.
    add_row(8'h01, 1'b1, 1'b0, 16'h0000);
    add_row(TypeBool, 1'b1, 1'b0, 16'h0000);
    add_row(8'h01, 1'b1, 1'b0, 16'hFFFF);
    add_row(8'h00, 1'b1, 1'b0, 16'h0000);
    add_row(8'hFF, 1'b1, 1'b0, 16'h0000);
    add_row(8'h00, 1'b1, 1'b1, 16'h0001, 1'b1, ST_VALID, 1, 6);
    // Zero key length.
    add_row(8'h00, 1'b1, 1'b0, 16'h0000);
    add_row(TypeInt, 1'b1, 1'b0, 16'h0000);
    add_row(8'h04, 1'b1, 1'b0, 16'h0000);
    add_row(8'h00, 1'b1, 1'b1, 16'h0000, 1'b1, ST_MALFORMED, 0, 0);
    // Payload ends inside the header of a number record with the longest key.
    add_row(8'h40, 1'b1, 1'b0, 16'h0000);
    add_row(TypeNumber, 1'b1, 1'b1, 16'h0000, 1'b1, ST_MALFORMED, 0, 0);
    // Type out of range.
    add_row(8'h01, 1'b1, 1'b0, 16'h0000);
    add_row(8'hFF, 1'b1, 1'b0, 16'h0000);
    add_row(8'h04, 1'b1, 1'b0, 16'h0000);
    add_row(8'h00, 1'b1, 1'b1, 16'h0000, 1'b1, ST_MALFORMED, 0, 0);
    foreach (dir_table[k]) offer_item(dir_table[k].stim, dir_table[k].typed, dir_table[k].want);

    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: program_limits(8'd64, 16'd4096, 10'd128, 17'd16384);
        1: program_limits(8'd255, 16'hFFFF, 10'd1023, 17'h10000);
        2: program_limits(8'd1, 16'd0, 10'd1, 17'd1);
        3: program_limits(8'd4, 16'd6, 10'd3, 17'd60);
        4: program_limits(8'd0, 16'd3, 10'd0, 17'h1FFFF);
        5: program_limits(8'd8, 16'd16, 10'd2, 17'd0);
        6: program_limits(8'd16, 16'd10, 10'd5, 17'd40);
        default: program_limits(8'($urandom), 16'($urandom), 10'($urandom),
                                17'($urandom_range(0, 131071)));
      endcase
      if (phase == 1) sink_hold_req = 1'b1;
      if (phase == PhaseCount - 1) quiet = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        build_payload();
        // Now and then let every report drain before the next payload.
        if (!quiet && !sink_hold_req && $urandom_range(0, 11) == 0) begin
          in_valid <= 1'b0;
          while (pending_reports.size() != 0) @(posedge clk);
        end
        foreach (payload_q[k]) begin
          offer_item(payload_q[k], 1'b0, no_report);
          if (payload_q[k].byte_present || payload_q[k].last) sent++;
        end
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("tlv_record_payload_validator_top_tb: PASS");
    end else begin
      $display("tlv_record_payload_validator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
